### src/tbpc_pkg.sv
// types and constants shared by the three-button press classifier
// standalone package, no dependencies
`default_nettype none

package tbpc_pkg;

  // press state: button*3 + phase + 1, idle is zero
  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_PREV_PEND = 4'd1,
    ST_PREV_HELD = 4'd2,
    ST_PREV_REL  = 4'd3,
    ST_PLAY_PEND = 4'd4,
    ST_PLAY_HELD = 4'd5,
    ST_PLAY_REL  = 4'd6,
    ST_NEXT_PEND = 4'd7,
    ST_NEXT_HELD = 4'd8,
    ST_NEXT_REL  = 4'd9
  } state_e;

  typedef enum logic [1:0] {
    BTN_PREV = 2'd0,
    BTN_PLAY = 2'd1,
    BTN_NEXT = 2'd2
  } btn_e;

  typedef enum logic [1:0] {
    PH_PEND = 2'd0,
    PH_HELD = 2'd1,
    PH_REL  = 2'd2
  } phase_e;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned EventW = 4;

  // configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LONG     = 1'b1;

  localparam logic [CfgW-1:0] DebounceReset = 16'd1;
  localparam logic [CfgW-1:0] LongReset     = 16'd20;

  // press event codes
  localparam logic [EventW-1:0] EV_NONE      = 4'd0;
  localparam logic [EventW-1:0] EV_PLAY_SHORT = 4'd1;
  localparam logic [EventW-1:0] EV_PLAY_LONG = 4'd2;
  localparam logic [EventW-1:0] EV_NEXT_SHORT = 4'd3;
  localparam logic [EventW-1:0] EV_NEXT_HOLD = 4'd4;
  localparam logic [EventW-1:0] EV_NEXT_LONG = 4'd5;
  localparam logic [EventW-1:0] EV_PREV_SHORT = 4'd6;
  localparam logic [EventW-1:0] EV_PREV_HOLD = 4'd7;
  localparam logic [EventW-1:0] EV_PREV_LONG = 4'd8;

  function automatic state_e st_code(input btn_e btn, input phase_e ph);
    state_e s;
    s = ST_IDLE;
    case (btn)
      BTN_PREV: s = (ph == PH_PEND) ? ST_PREV_PEND : (ph == PH_HELD) ? ST_PREV_HELD : ST_PREV_REL;
      BTN_PLAY: s = (ph == PH_PEND) ? ST_PLAY_PEND : (ph == PH_HELD) ? ST_PLAY_HELD : ST_PLAY_REL;
      BTN_NEXT: s = (ph == PH_PEND) ? ST_NEXT_PEND : (ph == PH_HELD) ? ST_NEXT_HELD : ST_NEXT_REL;
      default:  s = ST_IDLE;
    endcase
    return s;
  endfunction

  function automatic logic [EventW-1:0] ev_short(input btn_e btn);
    logic [EventW-1:0] e;
    case (btn)
      BTN_PREV: e = EV_PREV_SHORT;
      BTN_PLAY: e = EV_PLAY_SHORT;
      BTN_NEXT: e = EV_NEXT_SHORT;
      default:  e = EV_NONE;
    endcase
    return e;
  endfunction

  // play has no hold event
  function automatic logic [EventW-1:0] ev_hold(input btn_e btn);
    logic [EventW-1:0] e;
    case (btn)
      BTN_PREV: e = EV_PREV_HOLD;
      BTN_NEXT: e = EV_NEXT_HOLD;
      default:  e = EV_NONE;
    endcase
    return e;
  endfunction

  function automatic logic [EventW-1:0] ev_long(input btn_e btn);
    logic [EventW-1:0] e;
    case (btn)
      BTN_PREV: e = EV_PREV_LONG;
      BTN_PLAY: e = EV_PLAY_LONG;
      BTN_NEXT: e = EV_NEXT_LONG;
      default:  e = EV_NONE;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

### src/tbpc_classify.sv
// next-state and event logic for one button sample
// depends on tbpc_pkg
`default_nettype none

module tbpc_classify #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  var tbpc_pkg::state_e                 state_i,
  input  wire logic                            prev_level_i,
  input  wire logic                            play_level_i,
  input  wire logic                            next_level_i,
  input  wire logic                            tick_i,
  input  wire logic [COUNT_WIDTH-1:0]          cnt_i,
  input  wire logic [COUNT_WIDTH-1:0]          rel_i,
  input  wire logic [tbpc_pkg::CfgW-1:0]       debounce_i,
  input  wire logic [tbpc_pkg::CfgW-1:0]       long_i,
  output tbpc_pkg::state_e                     state_o,
  output logic [COUNT_WIDTH-1:0]               cnt_o,
  output logic                                 rel_load_o,
  output logic [tbpc_pkg::EventW-1:0]          event_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > tbpc_pkg::CfgW) ? COUNT_WIDTH : tbpc_pkg::CfgW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  tbpc_pkg::btn_e   btn;
  tbpc_pkg::phase_e ph;
  logic             code_ok;
  logic             up;
  logic             long_held;
  logic             long_rel;
  logic             rel_done;
  logic [COUNT_WIDTH-1:0] rel_span;
  logic [COUNT_WIDTH-1:0] cnt_base;

  // decode state into button and phase
  always_comb begin
    btn     = tbpc_pkg::BTN_PREV;
    ph      = tbpc_pkg::PH_PEND;
    code_ok = 1'b1;
    case (state_i)
      tbpc_pkg::ST_PREV_PEND: begin btn = tbpc_pkg::BTN_PREV; ph = tbpc_pkg::PH_PEND; end
      tbpc_pkg::ST_PREV_HELD: begin btn = tbpc_pkg::BTN_PREV; ph = tbpc_pkg::PH_HELD; end
      tbpc_pkg::ST_PREV_REL:  begin btn = tbpc_pkg::BTN_PREV; ph = tbpc_pkg::PH_REL;  end
      tbpc_pkg::ST_PLAY_PEND: begin btn = tbpc_pkg::BTN_PLAY; ph = tbpc_pkg::PH_PEND; end
      tbpc_pkg::ST_PLAY_HELD: begin btn = tbpc_pkg::BTN_PLAY; ph = tbpc_pkg::PH_HELD; end
      tbpc_pkg::ST_PLAY_REL:  begin btn = tbpc_pkg::BTN_PLAY; ph = tbpc_pkg::PH_REL;  end
      tbpc_pkg::ST_NEXT_PEND: begin btn = tbpc_pkg::BTN_NEXT; ph = tbpc_pkg::PH_PEND; end
      tbpc_pkg::ST_NEXT_HELD: begin btn = tbpc_pkg::BTN_NEXT; ph = tbpc_pkg::PH_HELD; end
      tbpc_pkg::ST_NEXT_REL:  begin btn = tbpc_pkg::BTN_NEXT; ph = tbpc_pkg::PH_REL;  end
      default: code_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (btn)
      tbpc_pkg::BTN_PREV: up = prev_level_i;
      tbpc_pkg::BTN_PLAY: up = play_level_i;
      tbpc_pkg::BTN_NEXT: up = next_level_i;
      default:            up = 1'b1;
    endcase
  end

  assign rel_span  = cnt_i - rel_i;
  assign long_held = CmpW'(cnt_i) > CmpW'(long_i);
  assign long_rel  = CmpW'(rel_i) > CmpW'(long_i);
  assign rel_done  = CmpW'(rel_span) >= CmpW'(debounce_i);

  always_comb begin
    state_o    = state_i;
    event_o    = tbpc_pkg::EV_NONE;
    rel_load_o = 1'b0;
    cnt_base   = cnt_i;
    if (state_i == tbpc_pkg::ST_IDLE) begin
      // priority prev, play, next; counter restarts
      cnt_base = '0;
      if (!prev_level_i) begin
        state_o = tbpc_pkg::ST_PREV_PEND;
      end else if (!play_level_i) begin
        state_o = tbpc_pkg::ST_PLAY_PEND;
      end else if (!next_level_i) begin
        state_o = tbpc_pkg::ST_NEXT_PEND;
      end
    end else if (!code_ok) begin
      state_o = tbpc_pkg::ST_IDLE;
    end else begin
      case (ph)
        tbpc_pkg::PH_PEND: begin
          if (up) begin
            state_o = tbpc_pkg::ST_IDLE;
          end else if (CmpW'(cnt_i) >= CmpW'(debounce_i)) begin
            state_o = tbpc_pkg::st_code(btn, tbpc_pkg::PH_HELD);
          end
        end
        tbpc_pkg::PH_HELD: begin
          if (up) begin
            state_o    = tbpc_pkg::st_code(btn, tbpc_pkg::PH_REL);
            rel_load_o = 1'b1;
          end
          if (long_held) begin
            event_o = tbpc_pkg::ev_hold(btn);
          end
        end
        default: begin
          if (!up) begin
            // bounce back to pressed
            state_o = tbpc_pkg::st_code(btn, tbpc_pkg::PH_HELD);
            if (long_rel) begin
              event_o = tbpc_pkg::ev_hold(btn);
            end
          end else if (rel_done) begin
            state_o = tbpc_pkg::ST_IDLE;
            event_o = long_rel ? tbpc_pkg::ev_long(btn) : tbpc_pkg::ev_short(btn);
          end else if (long_rel) begin
            event_o = tbpc_pkg::ev_hold(btn);
          end
        end
      endcase
    end
  end

  // tick applies after evaluation, saturating
  assign cnt_o = (tick_i && cnt_base != CntMax) ? cnt_base + 1'b1 : cnt_base;

endmodule

`default_nettype wire

### src/three_button_press_classifier_core.sv
// top level of the three-button press classifier: input register, classifier, result register
// depends on tbpc_pkg and tbpc_classify
`default_nettype none

// Debounces three active-low buttons (prev, play, next) and reports one press
// event per request. Each request carries the three button levels and a tick
// strobe; the tick advances a saturating counter after the request is judged.
// From idle the first pressed button is picked (prev over play over next), a
// press counts once the counter reaches debounce_ticks, and a release counts
// once debounce_ticks have passed since the release was seen. Releases report
// short or long-release, prev and next also report hold while held beyond
// long_press_ticks. Every request yields exactly one result, 0 meaning no event.
// Throughput is one request per cycle unless the result side stalls; each
// request passes the input register, then the result register. The press state,
// tick counter and release counter update once per request as it moves into
// the result register, which sets that rate. While a finished result
// waits in the output register, one more request is taken into the input
// register; after that the input stalls until the result is taken.
// Configuration: cfg_we_i writes register cfg_idx_i (0 debounce_ticks,
// 1 long_press_ticks) with cfg_data_i; write only while no request is in flight.

module three_button_press_classifier_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [tbpc_pkg::CfgW-1:0]     cfg_data_i,
  // request side
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          prev_level_i,
  input  wire logic                          play_level_i,
  input  wire logic                          next_level_i,
  input  wire logic                          tick_i,
  // result side
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tbpc_pkg::EventW-1:0]        press_event_o
);

  // configuration registers
  logic [tbpc_pkg::CfgW-1:0] debounce_q;
  logic [tbpc_pkg::CfgW-1:0] long_q;

  // input register
  logic in_valid_q;
  logic prev_q, play_q, next_q, tick_q;

  // block state
  tbpc_pkg::state_e       state_q, state_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] rel_q;
  logic                   rel_load;

  // result register
  logic                          out_valid_q;
  logic [tbpc_pkg::EventW-1:0]   event_q, event_d;

  logic advance;
  logic in_accept;

  // the staged request moves on when the result register is empty or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= tbpc_pkg::DebounceReset;
      long_q     <= tbpc_pkg::LongReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbpc_pkg::REG_DEBOUNCE: debounce_q <= cfg_data_i;
        tbpc_pkg::REG_LONG:     long_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      prev_q <= prev_level_i;
      play_q <= play_level_i;
      next_q <= next_level_i;
      tick_q <= tick_i;
    end
  end

  tbpc_classify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_classify (
    .state_i      (state_q),
    .prev_level_i (prev_q),
    .play_level_i (play_q),
    .next_level_i (next_q),
    .tick_i       (tick_q),
    .cnt_i        (cnt_q),
    .rel_i        (rel_q),
    .debounce_i   (debounce_q),
    .long_i       (long_q),
    .state_o      (state_d),
    .cnt_o        (cnt_d),
    .rel_load_o   (rel_load),
    .event_o      (event_d)
  );

  // state commits once per request, as it enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbpc_pkg::ST_IDLE;
      cnt_q   <= '0;
      rel_q   <= '0;
    end else if (advance) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (rel_load) begin
        rel_q <= cnt_q;  // count before this tick
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign press_event_o = event_q;

  // leaving idle restarts the counter: at most the one tick of that request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q == tbpc_pkg::ST_IDLE |=> cnt_q <= COUNT_WIDTH'(1))
    else $error("counter not restarted on leaving idle");

  // a request judged in idle never reports an event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q == tbpc_pkg::ST_IDLE |=> out_valid_q && event_q == tbpc_pkg::EV_NONE)
    else $error("event reported from idle");

  // state and counters move only with a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q) && $stable(cnt_q) && $stable(rel_q))
    else $error("state changed without a request");

  // a staged request held back by the result side stays staged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(tick_q) && $stable(prev_q))
    else $error("staged request lost under stall");

endmodule

`default_nettype wire
